/* design/eaua_pkg.sv */
// Shared widths, constants and divider handshake types for the encoder unwrap block.
`timescale 1ns / 1ps

package eaua_pkg;

  localparam int ANGLE_W  = 16;
  localparam int SENSOR_W = 15;
  localparam int TURN_W   = 32;
  localparam int TICK_W   = 32;
  localparam int VEL_W    = 16;
  localparam int GAIN_W   = 8;
  localparam int PEAK_W   = 8;

  // dividend register of the shared serial divider
  localparam int NUM_W    = VEL_W + GAIN_W;
  localparam int STEP_W   = $clog2(NUM_W + 1);

  localparam logic [STEP_W-1:0] VEL_STEPS = STEP_W'(ANGLE_W);
  localparam logic [STEP_W-1:0] ACC_STEPS = STEP_W'(NUM_W);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1);
  localparam logic [PEAK_W-1:0] ACCEL_MAX  = 8'hFF;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [NUM_W-1:0]  dividend;
    logic [TICK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* design/eaua_ifs.sv */
// Valid/ready channel interfaces for sample, result and gain configuration.
`timescale 1ns / 1ps

interface eaua_in_if;
  logic                         valid;
  logic                         ready;
  logic [eaua_pkg::ANGLE_W-1:0] raw_angle;
  logic [eaua_pkg::TICK_W-1:0]  tick_now;

  modport source (output valid, raw_angle, tick_now, input ready);
  modport sink (input valid, raw_angle, tick_now, output ready);
endinterface

interface eaua_out_if;
  logic                                valid;
  logic                                ready;
  logic [eaua_pkg::SENSOR_W-1:0]       sensor_angle;
  logic signed [eaua_pkg::TURN_W-1:0]  relative_angle;
  logic signed [eaua_pkg::VEL_W-1:0]   velocity;
  logic [eaua_pkg::PEAK_W-1:0]         peak_accel;

  modport source (output valid, sensor_angle, relative_angle, velocity, peak_accel,
                  input ready);
  modport sink (input valid, sensor_angle, relative_angle, velocity, peak_accel,
                output ready);
endinterface

interface eaua_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [eaua_pkg::GAIN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* design/eaua_div.sv */
// Radix-2 restoring divider: one quotient bit per cycle, step count set per request.
`timescale 1ns / 1ps

module eaua_div (
  input  logic               clk,
  input  logic               rst,
  input  eaua_pkg::div_req_t req,
  output eaua_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [eaua_pkg::STEP_W-1:0]   cnt;
  logic [eaua_pkg::NUM_W-1:0]    num;
  logic [eaua_pkg::NUM_W-1:0]    quo;
  logic [eaua_pkg::TICK_W-1:0]   rem;
  logic [eaua_pkg::TICK_W-1:0]   den;
  logic [eaua_pkg::TICK_W:0]     trial;
  logic [eaua_pkg::TICK_W:0]     diff;
  logic                          qbit;

  // bring down the next dividend bit and try the subtract
  assign trial = {rem, num[eaua_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign qbit  = ~diff[eaua_pkg::TICK_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        num  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        rem <= qbit ? diff[eaua_pkg::TICK_W-1:0] : trial[eaua_pkg::TICK_W-1:0];
        num <= {num[eaua_pkg::NUM_W-2:0], 1'b0};
        quo <= {quo[eaua_pkg::NUM_W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == eaua_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* design/encoder_angle_unwrap_accel_peak.sv */
// Top level: multi-turn angle unwrap, velocity and peak acceleration tracking.
`timescale 1ns / 1ps

// Takes one encoder reading (raw_angle, tick_now) at a time and returns one result per
// reading. The first reading after reset only latches the startup angle, and its result
// is loaded into the output register in the cycle after acceptance with velocity 0. Every
// later reading goes through VEL_START, VEL_WAIT, DELTA, ACC_START, ACC_WAIT and FINISH,
// where FINISH waits for the output register to free up. Both divisions by the tick delta
// run on one shared bit-serial divider. A new reading is accepted on the cycle after the
// previous one has been written to the output register, even if that result has not been
// taken yet, so no reading is taken while one is in flight. The gain register resets to 1
// and may be written at any time the block is idle; a tick delta of zero counts as 1.
module encoder_angle_unwrap_accel_peak (
  input logic       clk,
  input logic       rst,
  eaua_in_if.sink   sample,
  eaua_out_if.source result,
  eaua_cfg_if.sink  cfg
);

  typedef enum logic [2:0] {
    IDLE,
    VEL_START,
    VEL_WAIT,
    DELTA,
    ACC_START,
    ACC_WAIT,
    FINISH
  } state_t;

  state_t                        state;
  logic                          started;
  logic [eaua_pkg::TURN_W-1:0]   tracked;
  logic [eaua_pkg::ANGLE_W-1:0]  startup;
  logic [eaua_pkg::TICK_W-1:0]   last_tick;
  logic [eaua_pkg::VEL_W-1:0]    last_vel;
  logic [eaua_pkg::PEAK_W-1:0]   peak;
  logic [eaua_pkg::GAIN_W-1:0]   gain;

  logic [eaua_pkg::SENSOR_W-1:0] sensor_r;
  logic [eaua_pkg::TICK_W-1:0]   dt_r;
  logic                          neg_r;
  logic [eaua_pkg::ANGLE_W-1:0]  mag_r;
  logic [eaua_pkg::VEL_W-1:0]    vel_r;
  logic [eaua_pkg::VEL_W-1:0]    dv_r;

  logic                          out_valid;
  logic [eaua_pkg::SENSOR_W-1:0] out_sensor;
  logic [eaua_pkg::TURN_W-1:0]   out_rel;
  logic [eaua_pkg::VEL_W-1:0]    out_vel;
  logic [eaua_pkg::PEAK_W-1:0]   out_peak;

  logic [eaua_pkg::ANGLE_W-1:0]  d16;
  logic [eaua_pkg::TICK_W-1:0]   dt_raw;
  logic [eaua_pkg::VEL_W-1:0]    q_vel;
  logic [eaua_pkg::VEL_W:0]      vdiff;
  logic [eaua_pkg::VEL_W:0]      vdiff_neg;
  logic [eaua_pkg::VEL_W-1:0]    dv;
  logic [eaua_pkg::NUM_W-1:0]    prod;
  logic [eaua_pkg::PEAK_W-1:0]   acc_sat;
  logic                          take;

  eaua_pkg::div_req_t            div_req;
  eaua_pkg::div_rsp_t            div_rsp;

  eaua_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign take   = sample.valid && (state == IDLE);
  assign d16    = sample.raw_angle - tracked[eaua_pkg::ANGLE_W-1:0];
  assign dt_raw = sample.tick_now - last_tick;

  assign q_vel     = div_rsp.quotient[eaua_pkg::VEL_W-1:0];
  assign vdiff     = {vel_r[eaua_pkg::VEL_W-1], vel_r} - {last_vel[eaua_pkg::VEL_W-1], last_vel};
  assign vdiff_neg = -vdiff;
  assign dv        = vdiff[eaua_pkg::VEL_W] ? vdiff_neg[eaua_pkg::VEL_W-1:0]
                                            : vdiff[eaua_pkg::VEL_W-1:0];
  assign prod      = {{eaua_pkg::GAIN_W{1'b0}}, dv_r} * {{eaua_pkg::VEL_W{1'b0}}, gain};
  // clamp the acceleration quotient to 8 bits
  assign acc_sat   = (|div_rsp.quotient[eaua_pkg::NUM_W-1:eaua_pkg::PEAK_W]) ? eaua_pkg::ACCEL_MAX
                   : div_rsp.quotient[eaua_pkg::PEAK_W-1:0];

  always_comb begin
    div_req.start    = (state == VEL_START) || (state == ACC_START);
    div_req.divisor  = dt_r;
    if (state == VEL_START) begin
      div_req.steps    = eaua_pkg::VEL_STEPS;
      div_req.dividend = {mag_r, {(eaua_pkg::NUM_W - eaua_pkg::ANGLE_W){1'b0}}};
    end else begin
      div_req.steps    = eaua_pkg::ACC_STEPS;
      div_req.dividend = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      started   <= 1'b0;
      tracked   <= '0;
      startup   <= '0;
      last_tick <= '0;
      last_vel  <= '0;
      peak      <= '0;
      gain      <= eaua_pkg::GAIN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        gain <= cfg.data;
      end
      // FINISH reloads the output register itself
      if (out_valid && result.ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (take) begin
            sensor_r <= sample.raw_angle[eaua_pkg::ANGLE_W-1:1];
            if (!started) begin
              started <= 1'b1;
              tracked <= {{(eaua_pkg::TURN_W - eaua_pkg::ANGLE_W){1'b0}}, sample.raw_angle};
              startup <= sample.raw_angle;
              vel_r   <= '0;
              state   <= FINISH;
            end else begin
              tracked   <= tracked
                         + {{(eaua_pkg::TURN_W - eaua_pkg::ANGLE_W){d16[eaua_pkg::ANGLE_W-1]}}, d16};
              last_tick <= sample.tick_now;
              dt_r      <= (dt_raw == '0) ? eaua_pkg::TICK_W'(1) : dt_raw;
              neg_r     <= d16[eaua_pkg::ANGLE_W-1];
              mag_r     <= d16[eaua_pkg::ANGLE_W-1] ? -d16 : d16;
              state     <= VEL_START;
            end
          end
        end
        VEL_START: begin
          state <= VEL_WAIT;
        end
        VEL_WAIT: begin
          if (div_rsp.done) begin
            vel_r <= neg_r ? -q_vel : q_vel;
            state <= DELTA;
          end
        end
        DELTA: begin
          dv_r     <= dv;
          last_vel <= vel_r;
          state    <= ACC_START;
        end
        ACC_START: begin
          state <= ACC_WAIT;
        end
        ACC_WAIT: begin
          if (div_rsp.done) begin
            if (acc_sat > peak) begin
              peak <= acc_sat;
            end
            state <= FINISH;
          end
        end
        FINISH: begin
          // wait for the output register to free up
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_sensor <= sensor_r;
            out_rel    <= tracked - {{(eaua_pkg::TURN_W - eaua_pkg::ANGLE_W){1'b0}}, startup};
            out_vel    <= vel_r;
            out_peak   <= peak;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign sample.ready          = (state == IDLE);
  assign cfg.ready             = 1'b1;
  assign result.valid          = out_valid;
  assign result.sensor_angle   = out_sensor;
  assign result.relative_angle = out_rel;
  assign result.velocity       = out_vel;
  assign result.peak_accel     = out_peak;

endmodule

/* sim/tb.sv */
// Testbench for the multi-turn encoder angle unwrapper with velocity and peak acceleration.
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 4000;  // cycles with no transaction before the run is abandoned
  localparam int HOLD_LONG  = 400;

  typedef struct packed {
    logic [eaua_pkg::SENSOR_W-1:0]       sensor_angle;
    logic signed [eaua_pkg::TURN_W-1:0]  relative_angle;
    logic signed [eaua_pkg::VEL_W-1:0]   velocity;
    logic [eaua_pkg::PEAK_W-1:0]         peak_accel;
  } angle_result_t;

  logic clk;
  logic rst;

  eaua_in_if  sample_if ();
  eaua_out_if result_if ();
  eaua_cfg_if cfg_if ();

  encoder_angle_unwrap_accel_peak dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // unwrap tracker state
  logic                         trk_started;
  logic [eaua_pkg::TURN_W-1:0]  trk_angle;
  logic [eaua_pkg::ANGLE_W-1:0] trk_startup;
  logic [eaua_pkg::TICK_W-1:0]  trk_last_tick;
  longint                       trk_last_vel;
  logic [eaua_pkg::PEAK_W-1:0]  trk_peak;
  logic [eaua_pkg::GAIN_W-1:0]  trk_gain;

  angle_result_t expected_angles[$];
  int mismatch_count = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req = 0;
  int hold_ack = 0;
  int rx_hold = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic angle_result_t unwrap_reading(logic [eaua_pkg::ANGLE_W-1:0] raw,
                                                   logic [eaua_pkg::TICK_W-1:0] tick);
    angle_result_t r;
    logic [eaua_pkg::ANGLE_W-1:0] d16;
    logic [eaua_pkg::TICK_W-1:0] dt32;
    longint diff, mag, dt, q, vel, dv, acc;
    vel = 0;
    if (!trk_started) begin
      trk_started = 1'b1;
      trk_angle = {16'h0, raw};
      trk_startup = raw;
    end else begin
      d16 = raw - trk_angle[15:0];
      diff = longint'($signed(d16));
      dt32 = tick - trk_last_tick;
      dt = longint'(dt32);
      trk_angle = trk_angle + eaua_pkg::TURN_W'(diff);
      trk_last_tick = tick;
      if (dt == 0) dt = 1;
      mag = (diff < 0) ? -diff : diff;
      q = mag / dt;
      vel = (diff < 0) ? -q : q;
      dv = vel - trk_last_vel;
      if (dv < 0) dv = -dv;
      acc = (dv * longint'(trk_gain)) / dt;
      trk_last_vel = vel;
      if (acc > longint'(eaua_pkg::ACCEL_MAX)) acc = longint'(eaua_pkg::ACCEL_MAX);
      if (acc > longint'(trk_peak)) trk_peak = eaua_pkg::PEAK_W'(acc);
    end
    r.sensor_angle = raw[eaua_pkg::ANGLE_W-1:1];
    r.relative_angle = trk_angle - {16'h0, trk_startup};
    r.velocity = eaua_pkg::VEL_W'(vel);
    r.peak_accel = trk_peak;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  task automatic send_reading(input logic [eaua_pkg::ANGLE_W-1:0] raw,
                              input logic [eaua_pkg::TICK_W-1:0] tick);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.raw_angle <= raw;
    sample_if.tick_now <= tick;
    do @(posedge clk); while (!sample_if.ready);
    expected_angles.push_back(unwrap_reading(raw, tick));
  endtask

  // next reading offset from the tracked angle and the last tick
  task automatic step_by(input int diff, input logic [eaua_pkg::TICK_W-1:0] dt);
    send_reading(trk_angle[15:0] + eaua_pkg::ANGLE_W'(diff), trk_last_tick + dt);
  endtask

  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gain(input logic [eaua_pkg::GAIN_W-1:0] g);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= g;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    trk_gain = g;
  endtask

  task automatic random_reading();
    int roll, v, d, diff;
    logic [eaua_pkg::TICK_W-1:0] dt;
    roll = $urandom_range(99);
    if (roll < 20) begin
      // noise: arbitrary angle and tick, usually a huge tick delta
      send_reading(eaua_pkg::ANGLE_W'($urandom()), $urandom());
    end else begin
      dt = (roll < 25) ? '0 : eaua_pkg::TICK_W'($urandom_range(1, 200));
      d = (dt == 0) ? 1 : int'(dt);
      v = int'($urandom_range(80)) - 40;
      diff = v * d + int'($urandom_range(2 * d)) - d;
      step_by(diff, dt);
    end
  endtask

  task automatic test_first_reading();
    send_reading(16'hFFFF, 32'hFFFF_FFF0);
  endtask

  task automatic test_wrap_and_ticks();
    step_by(1, 32'h0000_0110);            // angle wraps 0xFFFF -> 0x0000
    step_by(5, 32'h0);                    // zero tick delta counts as one
    step_by(32762, 32'h0010_0000);
    step_by(32767, 32'h0010_0000);        // largest forward step
    step_by(-32768, 32'h0010_0000);       // largest backward step
    step_by(-32768, 32'h0010_0000);
    send_reading(16'h0000, 32'hFFFF_FFFF);
    step_by(-1, 32'h0000_0001);           // tick count wraps to zero
    step_by(30000, 32'h0100_0000);
    step_by(30000, 32'h0100_0000);
    step_by(30000, 32'h0100_0000);        // more than one turn
    step_by(-7, 32'h0000_0003);           // truncation toward zero
    step_by(7, 32'h0000_0003);
  endtask

  task automatic test_gain_zero();
    write_gain(8'h00);
    step_by(32767, 32'h1);
    step_by(-32768, 32'h1);
    step_by(0, 32'h1);                    // settle velocity back to zero
  endtask

  task automatic run_random(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) random_reading();
  endtask

  task automatic test_random_rx_stall();
    write_gain(8'h01);
    run_random(170, 22, 65);
  endtask

  task automatic test_random_tx_stall();
    write_gain(eaua_pkg::GAIN_W'($urandom_range(2, 64)));
    run_random(170, 65, 22);
  endtask

  task automatic test_random_full_rate();
    write_gain(eaua_pkg::GAIN_W'($urandom_range(0, 255)));
    run_random(130, 0, 0);
  endtask

  task automatic test_backpressure();
    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req++;
    repeat (8) random_reading();
    // sender pauses until every result is back
    wait_idle();
    repeat (4) random_reading();
  endtask

  // runs last: the peak only ever rises
  task automatic test_accel_saturation();
    write_gain(8'hFF);
    tx_idle_pct = 22;
    rx_idle_pct = 22;
    step_by(1000, 32'h1);
    step_by(-1000, 32'h1);
    step_by(0, 32'h0);
  endtask

  // result receiver with random and long hold-offs
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      rx_hold = HOLD_LONG;
      hold_ack = hold_req;
    end
    if (rx_hold != 0) begin
      rx_hold--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    angle_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_angles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result transaction with no reading pending", $realtime);
      end else begin
        want = expected_angles.pop_front();
        if (result_if.sensor_angle !== want.sensor_angle)
          note_mismatch("sensor_angle", want.sensor_angle, result_if.sensor_angle);
        if (result_if.relative_angle !== want.relative_angle)
          note_mismatch("relative_angle", want.relative_angle, result_if.relative_angle);
        if (result_if.velocity !== want.velocity)
          note_mismatch("velocity", want.velocity, result_if.velocity);
        if (result_if.peak_accel !== want.peak_accel)
          note_mismatch("peak_accel", want.peak_accel, result_if.peak_accel);
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    trk_started = 1'b0;
    trk_angle = '0;
    trk_startup = '0;
    trk_last_tick = '0;
    trk_last_vel = 0;
    trk_peak = '0;
    trk_gain = eaua_pkg::GAIN_RESET;
    tx_idle_pct = 22;
    rx_idle_pct = 65;
    rst <= 1'b1;
    sample_if.valid <= 1'b0;
    sample_if.raw_angle <= '0;
    sample_if.tick_now <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_reading();
    test_wrap_and_ticks();
    test_gain_zero();
    test_random_rx_stall();
    test_random_tx_stall();
    test_random_full_rate();
    test_backpressure();
    test_accel_saturation();

    sample_if.valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && expected_angles.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* encoder_angle_unwrap_accel_peak.f */
design/eaua_pkg.sv
design/eaua_ifs.sv
design/eaua_div.sv
design/encoder_angle_unwrap_accel_peak.sv
sim/tb.sv
